// File: sv/first_fit_partition_allocator_unit_defines.svh
// Assertion macros for the first-fit partition allocator.
// Used by the top level only; no other dependencies.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FFPA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define FFPA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ffpa_pkg.sv
// Shared types, codes and reset constants for the partition allocator.
// No dependencies; imported by every module of the block.
package ffpa_pkg;

	localparam int unsigned MAX_JOBS_DEF = 16;

	localparam logic [15:0] TOTAL_RST   = 16'd5000;
	localparam logic [14:0] BASE_RST    = 15'd2000;
	localparam logic [15:0] MINFRAG_RST = 16'd100;
	localparam logic [15:0] REGION_MAX  = 16'd32768;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_LEN    = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_NO_SPACE   = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_DUP_ID     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CFG_TOTAL   = 2'd0,
		CFG_BASE    = 2'd1,
		CFG_MINFRAG = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_FIT, S_CLOAD, S_CRUN, S_CWRITE,
		S_GRANT, S_RSCAN, S_RMERGE, S_RDROP, S_RESP
	} fsm_t;

	typedef enum logic [2:0] {
		JOP_NONE, JOP_CLEAR, JOP_WRITE, JOP_FREE, JOP_RLOAD, JOP_RSTEP, JOP_PACK
	} jop_t;

	typedef enum logic [2:0] {
		FOP_NONE, FOP_INIT, FOP_SET, FOP_REMOVE, FOP_INSERT
	} fop_t;

	// Command to the job cells; addr carries the region top on a pack
	typedef struct packed {
		jop_t        op;
		logic [7:0]  id;
		logic [15:0] addr;
		logic [15:0] len;
	} job_cmd_t;

	typedef struct packed {
		logic        v;
		logic [15:0] addr;
		logic [15:0] len;
	} job_tok_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  id;
		logic [15:0] addr;
		logic [15:0] len;
	} job_view_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] addr;
		logic [15:0] size;
	} free_ent_t;

	typedef struct packed {
		fop_t      op;
		free_ent_t ent;
	} free_cmd_t;

endpackage

// File: sv/first_fit_partition_allocator_unit.sv
// First-fit partition allocator: sequencer over a row of job cells and free cells.
// Depends on ffpa_pkg, ffpa_job_cell, ffpa_free_cell and the defines header.
//
// Use: drive req_type, job_id and request_length with start high while busy
// is low; the request is taken at that edge. One result per request appears
// with done high for exactly one cycle; the receiver cannot stall, so the
// result must be taken then. busy stays high from acceptance to the done cycle.
// Sequence: a fitting allocate scans the free list from the first block to the
// first one that fits, then grants. An allocate that compacts scans the whole
// free list, loads the job token ring, steps it round all MAX_JOBS job cells,
// packs the jobs and grants. A release scans up to the first free block above
// the job, then merges; a three-way merge adds a step to drop a free block.
// Rejected requests answer straight from the check.
// Rate is one request at a time, set by the free-list scan and the ring.
// Reset clears all jobs and leaves one free block of the whole region; a
// write of register index 0, 1 or 2 does the same with the new value.
// Configuration may only be written while busy is low.
`include "first_fit_partition_allocator_unit_defines.svh"
module first_fit_partition_allocator_unit #(
	parameter int unsigned MAX_JOBS = ffpa_pkg::MAX_JOBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  job_id,
	input  logic [15:0] request_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] granted_address,
	output logic [15:0] granted_length,
	output logic        did_compact,
	output logic [15:0] free_total
);
	import ffpa_pkg::*;

	localparam int unsigned FREE_CAP = MAX_JOBS + 1;
	localparam int unsigned JIW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned JCW = $clog2(MAX_JOBS + 1);
	localparam int unsigned FIW = $clog2(FREE_CAP);
	localparam int unsigned KW  = $clog2(FREE_CAP + 1);

	fsm_t        state_q, state_d;
	logic        type_q;
	logic [7:0]  id_q;
	logic [15:0] len_q;
	logic [15:0] total_q;
	logic [14:0] base_q;
	logic [15:0] minfrag_q;
	logic [15:0] unused_q;
	logic [JCW-1:0] jcount_q;
	logic [KW-1:0]  k_q;
	logic [JCW-1:0] ring_q;
	logic [JIW-1:0] slot_q;
	logic [15:0] rel_addr_q, rel_len_q;
	logic        prev_valid_q;
	logic [15:0] prev_addr_q, prev_size_q;
	status_t     st_q;
	logic [15:0] gaddr_q, glen_q;
	logic        comp_q;

	job_cmd_t    jcmd;
	logic [JIW-1:0] jslot;
	job_view_t   jv   [MAX_JOBS];
	job_tok_t    jtok [MAX_JOBS];
	logic [MAX_JOBS-1:0] jhit, jvalid, jsel;
	free_cmd_t   fcmd;
	logic [KW-1:0] ftgt;
	free_ent_t   fe [FREE_CAP];
	logic [FREE_CAP-1:0] fvalid;

	logic [15:0] region, region_n, total_n, mf_n, top_addr;
	logic [14:0] base_n;
	logic        cfg_hit;
	logic [JIW-1:0] hit_idx, free_slot;
	logic        hit_any;
	free_ent_t   rd;
	logic        bad_len, full, short_space, fit_ok, small_left, scan_stop;
	logic        below, above;
	logic [15:0] grant;

	// Job cells: a ring for compaction
	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_job
		assign jsel[i]   = (jslot == JIW'(i));
		assign jvalid[i] = jv[i].valid;
		ffpa_job_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (jcmd),
			.sel     (jsel[i]),
			.tok_in  (jtok[(i + MAX_JOBS - 1) % MAX_JOBS]),
			.tok_out (jtok[i]),
			.view    (jv[i]),
			.hit     (jhit[i])
		);
	end

	// Free cells: a chain in address order
	for (genvar i = 0; i < FREE_CAP; i++) begin : g_free
		free_ent_t lo_ent, hi_ent;
		assign fvalid[i] = fe[i].valid;
		if (i == 0) begin : g_lo0
			assign lo_ent = '0;
		end else begin : g_lo
			assign lo_ent = fe[i-1];
		end
		if (i == FREE_CAP - 1) begin : g_hiN
			assign hi_ent = '0;
		end else begin : g_hi
			assign hi_ent = fe[i+1];
		end
		ffpa_free_cell #(.RST_VALID((i == 0) ? 1'b1 : 1'b0)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (fcmd),
			.sel     (ftgt == KW'(i)),
			.gt      (ftgt < KW'(i)),
			.from_lo (lo_ent),
			.from_hi (hi_ent),
			.ent     (fe[i])
		);
	end

	// Register values after a configuration write
	always_comb begin
		total_n = total_q;
		base_n  = base_q;
		mf_n    = minfrag_q;
		cfg_hit = 1'b0;
		case (cfg_idx_t'(cfg_index))
			CFG_TOTAL: begin
				total_n = cfg_wdata;
				cfg_hit = cfg_we;
			end
			CFG_BASE: begin
				base_n  = cfg_wdata[14:0];
				cfg_hit = cfg_we;
			end
			CFG_MINFRAG: begin
				mf_n    = cfg_wdata;
				cfg_hit = cfg_we;
			end
			default: ;
		endcase
		region_n = (total_n > REGION_MAX) ? REGION_MAX : total_n;
	end

	assign region   = (total_q > REGION_MAX) ? REGION_MAX : total_q;
	assign top_addr = {1'b0, base_q} + region;

	// Locate the job by id and the first empty slot
	always_comb begin
		hit_idx   = '0;
		free_slot = '0;
		for (int i = 0; i < MAX_JOBS; i++)
			if (jhit[i]) hit_idx = hit_idx | JIW'(i);
		for (int i = MAX_JOBS - 1; i >= 0; i--)
			if (!jvalid[i]) free_slot = JIW'(i);
	end
	assign hit_any = |jhit;

	// Free cell under the scan pointer
	assign rd = (k_q < KW'(FREE_CAP)) ? fe[k_q[FIW-1:0]] : '0;

	assign bad_len     = (len_q == '0) || (len_q > region);
	assign full        = (jcount_q >= JCW'(MAX_JOBS));
	assign short_space = (unused_q < len_q);
	assign fit_ok      = rd.valid && (rd.size >= len_q);
	assign small_left  = (rd.size - len_q) < minfrag_q;
	assign grant       = small_left ? rd.size : len_q;
	assign scan_stop   = !rd.valid || (rd.addr > rel_addr_q);
	assign below       = prev_valid_q && ((prev_addr_q + prev_size_q) == rel_addr_q);
	assign above       = rd.valid && (rd.addr == rel_addr_q + rel_len_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// Next state and cell commands
	always_comb begin
		state_d   = state_q;
		jcmd      = '{op: JOP_NONE, id: id_q, addr: '0, len: '0};
		jslot     = slot_q;
		fcmd      = '0;
		fcmd.op   = FOP_NONE;
		ftgt      = k_q;
		case (state_q)
			S_IDLE: begin
				if (cfg_hit) begin
					jcmd.op = JOP_CLEAR;
					fcmd    = '{op: FOP_INIT,
						ent: '{valid: region_n != '0, addr: {1'b0, base_n}, size: region_n}};
					ftgt    = '0;
				end else if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (type_q == REQ_ALLOC)
					state_d = (bad_len || hit_any || full || short_space) ? S_RESP : S_FIT;
				else
					state_d = hit_any ? S_RSCAN : S_RESP;
			end
			S_FIT: begin
				if (!rd.valid)   state_d = S_CLOAD;
				else if (fit_ok) state_d = S_GRANT;
			end
			S_CLOAD: begin
				jcmd.op = JOP_RLOAD;
				state_d = S_CRUN;
			end
			S_CRUN: begin
				jcmd.op = JOP_RSTEP;
				if (ring_q == JCW'(MAX_JOBS - 1)) state_d = S_CWRITE;
			end
			S_CWRITE: begin
				jcmd.op   = JOP_PACK;
				jcmd.addr = top_addr;
				fcmd      = '{op: FOP_INIT,
					ent: '{valid: unused_q != '0, addr: {1'b0, base_q}, size: unused_q}};
				ftgt      = '0;
				state_d   = S_GRANT;
			end
			S_GRANT: begin
				if (fit_ok) begin
					jcmd  = '{op: JOP_WRITE, id: id_q, addr: rd.addr, len: grant};
					jslot = free_slot;
					if (small_left)
						fcmd.op = FOP_REMOVE;
					else
						fcmd = '{op: FOP_SET,
							ent: '{valid: 1'b1, addr: rd.addr + len_q, size: rd.size - len_q}};
				end
				state_d = S_RESP;
			end
			S_RSCAN: begin
				if (scan_stop) state_d = S_RMERGE;
			end
			S_RMERGE: begin
				jcmd.op = JOP_FREE;
				state_d = S_RESP;
				if (below && above) begin
					fcmd = '{op: FOP_SET, ent: '{valid: 1'b1, addr: prev_addr_q,
						size: prev_size_q + rel_len_q + rd.size}};
					ftgt    = k_q - KW'(1);
					state_d = S_RDROP;
				end else if (below) begin
					fcmd = '{op: FOP_SET, ent: '{valid: 1'b1, addr: prev_addr_q,
						size: prev_size_q + rel_len_q}};
					ftgt = k_q - KW'(1);
				end else if (above) begin
					fcmd = '{op: FOP_SET, ent: '{valid: 1'b1, addr: rel_addr_q,
						size: rd.size + rel_len_q}};
				end else if (!fvalid[FREE_CAP-1]) begin
					fcmd = '{op: FOP_INSERT, ent: '{valid: 1'b1, addr: rel_addr_q,
						size: rel_len_q}};
				end
			end
			S_RDROP: begin
				fcmd.op = FOP_REMOVE;
				state_d = S_RESP;
			end
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Request, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q       <= REQ_ALLOC;
			id_q         <= '0;
			len_q        <= '0;
			total_q      <= TOTAL_RST;
			base_q       <= BASE_RST;
			minfrag_q    <= MINFRAG_RST;
			unused_q     <= TOTAL_RST;
			jcount_q     <= '0;
			k_q          <= '0;
			ring_q       <= '0;
			slot_q       <= '0;
			rel_addr_q   <= '0;
			rel_len_q    <= '0;
			prev_valid_q <= 1'b0;
			prev_addr_q  <= '0;
			prev_size_q  <= '0;
			st_q         <= ST_OK;
			gaddr_q      <= '0;
			glen_q       <= '0;
			comp_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_hit) begin
						total_q   <= total_n;
						base_q    <= base_n;
						minfrag_q <= mf_n;
						unused_q  <= region_n;
						jcount_q  <= '0;
					end else if (start) begin
						type_q       <= req_type;
						id_q         <= job_id;
						len_q        <= request_length;
						k_q          <= '0;
						prev_valid_q <= 1'b0;
						st_q         <= ST_OK;
						gaddr_q      <= '0;
						glen_q       <= '0;
						comp_q       <= 1'b0;
					end
				end
				S_CHECK: begin
					if (type_q == REQ_ALLOC) begin
						if (bad_len)          st_q <= ST_BAD_LEN;
						else if (hit_any)     st_q <= ST_DUP_ID;
						else if (full)        st_q <= ST_TABLE_FULL;
						else if (short_space) st_q <= ST_NO_SPACE;
					end else if (!hit_any) begin
						st_q <= ST_NOT_FOUND;
					end else begin
						slot_q     <= hit_idx;
						rel_addr_q <= jv[hit_idx].addr;
						rel_len_q  <= jv[hit_idx].len;
					end
				end
				S_FIT: begin
					if (rd.valid && !fit_ok) k_q <= k_q + KW'(1);
				end
				S_CLOAD: ring_q <= '0;
				S_CRUN:  ring_q <= ring_q + JCW'(1);
				S_CWRITE: begin
					k_q    <= '0;
					comp_q <= 1'b1;
				end
				S_GRANT: begin
					if (fit_ok) begin
						gaddr_q  <= rd.addr;
						glen_q   <= grant;
						jcount_q <= jcount_q + JCW'(1);
						unused_q <= unused_q - grant;
					end else begin
						st_q <= ST_NO_SPACE;
					end
				end
				S_RSCAN: begin
					if (!scan_stop) begin
						prev_valid_q <= 1'b1;
						prev_addr_q  <= rd.addr;
						prev_size_q  <= rd.size;
						k_q          <= k_q + KW'(1);
					end
				end
				S_RMERGE: begin
					jcount_q <= jcount_q - JCW'(1);
					unused_q <= unused_q + rel_len_q;
					glen_q   <= rel_len_q;
				end
				default: ;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = (state_q == S_RESP);
	assign status          = st_q;
	assign granted_address = gaddr_q;
	assign granted_length  = glen_q;
	assign did_compact     = comp_q;
	assign free_total      = unused_q;

	// Checks
	`FFPA_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request taken but not busy")
	`FFPA_ASSERT_IMP(a_free_packed, clk, arst_n, 1'b1, ((fvalid >> 1) & ~fvalid) == '0, "free list has a gap")
	`FFPA_ASSERT_IMP(a_job_count, clk, arst_n, 1'b1, $countones(jvalid) == int'(jcount_q), "job count out of step")
	`FFPA_ASSERT_IMP(a_addr_zero, clk, arst_n, done && (st_q != ST_OK || type_q == REQ_RELEASE), granted_address == '0, "address shown without grant")

endmodule

// File: sv/ffpa_job_cell.sv
// One job table entry with its slot of the compaction token ring.
// Depends on ffpa_pkg.
module ffpa_job_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ffpa_pkg::job_cmd_t  cmd,
	input  logic                sel,
	input  ffpa_pkg::job_tok_t  tok_in,
	output ffpa_pkg::job_tok_t  tok_out,
	output ffpa_pkg::job_view_t view,
	output logic                hit
);
	import ffpa_pkg::*;

	logic        valid_q;
	logic [7:0]  id_q;
	logic [15:0] addr_q;
	logic [15:0] len_q;
	job_tok_t    tok_q;
	logic [15:0] acc_q;

	// Hold the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				JOP_CLEAR: valid_q <= 1'b0;
				JOP_WRITE: if (sel) valid_q <= 1'b1;
				JOP_FREE:  if (sel) valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Load the entry, or move it to its packed place
	always_ff @(posedge clk) begin
		if (cmd.op == JOP_WRITE && sel) begin
			id_q   <= cmd.id;
			addr_q <= cmd.addr;
			len_q  <= cmd.len;
		end else if (cmd.op == JOP_PACK && valid_q) begin
			addr_q <= cmd.addr - acc_q;
		end
	end

	// Rotate tokens round the ring; sum lengths of jobs at or above this one
	always_ff @(posedge clk) begin
		if (cmd.op == JOP_RLOAD) begin
			tok_q <= '{v: valid_q, addr: addr_q, len: len_q};
			acc_q <= '0;
		end else if (cmd.op == JOP_RSTEP) begin
			if (tok_q.v && tok_q.addr >= addr_q)
				acc_q <= acc_q + tok_q.len;
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
	assign view    = '{valid: valid_q, id: id_q, addr: addr_q, len: len_q};
	assign hit     = valid_q && (id_q == cmd.id);

endmodule

// File: sv/ffpa_free_cell.sv
// One free-list entry; shifts to or from its neighbours on insert and remove.
// Depends on ffpa_pkg.
module ffpa_free_cell #(
	parameter logic RST_VALID = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffpa_pkg::free_cmd_t cmd,
	input  logic                sel,
	input  logic                gt,
	input  ffpa_pkg::free_ent_t from_lo,
	input  ffpa_pkg::free_ent_t from_hi,
	output ffpa_pkg::free_ent_t ent
);
	import ffpa_pkg::*;

	free_ent_t ent_q;

	// Hold, load or take the neighbour's entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{valid: RST_VALID, addr: {1'b0, BASE_RST}, size: TOTAL_RST};
		end else begin
			case (cmd.op)
				FOP_INIT: begin
					if (sel) ent_q <= cmd.ent;
					else     ent_q.valid <= 1'b0;
				end
				FOP_SET: if (sel) ent_q <= cmd.ent;
				FOP_REMOVE: if (sel || gt) ent_q <= from_hi;
				FOP_INSERT: begin
					if (sel)     ent_q <= cmd.ent;
					else if (gt) ent_q <= from_lo;
				end
				default: ;
			endcase
		end
	end

	assign ent = ent_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for first_fit_partition_allocator_unit.
// Depends on ffpa_pkg and the block's RTL; tracks the region in a scoreboard class.
import ffpa_pkg::*;

typedef struct {
	status_t     st;
	logic [15:0] addr;
	logic [15:0] len;
	logic        compacted;
	logic [15:0] free;
} grant_t;

class partition_tracker;
	int unsigned total, base, min_frag;
	bit          job_ok[16];
	int unsigned job_tag[16], job_addr[16], job_len[16];
	int unsigned hole_addr[17], hole_size[17];
	int unsigned hole_count, unused, jobs;
	grant_t      grants_due[$];
	int unsigned mismatches;

	function new();
		total = 32'(TOTAL_RST);
		base = 32'(BASE_RST);
		min_frag = 32'(MINFRAG_RST);
		mismatches = 0;
		clear_region();
	endfunction

	function int unsigned region();
		return (total > 32768) ? 32768 : total;
	endfunction

	function void clear_region();
		foreach (job_ok[i]) job_ok[i] = 0;
		hole_count = 0;
		if (region() > 0) begin
			hole_addr[0] = base;
			hole_size[0] = region();
			hole_count = 1;
		end
		unused = region();
		jobs = 0;
	endfunction

	function void configure(cfg_idx_t idx, logic [15:0] value);
		case (idx)
			CFG_TOTAL:   total = 32'(value);
			CFG_BASE:    base = 32'(value[14:0]);
			CFG_MINFRAG: min_frag = 32'(value);
			default: ;
		endcase
		clear_region();
	endfunction

	function int find_job(int unsigned tag);
		for (int i = 0; i < 16; i++)
			if (job_ok[i] && job_tag[i] == tag) return i;
		return -1;
	endfunction

	function void drop_hole(int unsigned i);
		for (int unsigned q = i; q + 1 < hole_count; q++) begin
			hole_addr[q] = hole_addr[q + 1];
			hole_size[q] = hole_size[q + 1];
		end
		hole_count--;
	endfunction

	// Pack jobs against the top, highest address first, one hole at the base
	function void compact();
		bit          placed[16];
		int unsigned top;
		int          best;
		top = base + region();
		foreach (placed[i]) placed[i] = 0;
		for (int unsigned k = 0; k < jobs; k++) begin
			best = -1;
			for (int i = 0; i < 16; i++)
				if (job_ok[i] && !placed[i] && (best < 0 || job_addr[i] > job_addr[best]))
					best = i;
			if (best < 0) break;
			placed[best] = 1;
			top -= job_len[best];
			job_addr[best] = top;
		end
		hole_count = 0;
		if (unused > 0) begin
			hole_addr[0] = base;
			hole_size[0] = unused;
			hole_count = 1;
		end
	endfunction

	function status_t allocate(int unsigned tag, int unsigned len, output int unsigned a,
			output int unsigned g, output bit c);
		int unsigned i;
		int          slot;
		a = 0; g = 0; c = 0;
		if (len == 0 || len > region()) return ST_BAD_LEN;
		if (find_job(tag) >= 0) return ST_DUP_ID;
		if (jobs >= 16) return ST_TABLE_FULL;
		if (unused < len) return ST_NO_SPACE;
		for (i = 0; i < hole_count; i++)
			if (hole_size[i] >= len) break;
		if (i == hole_count) begin
			compact();
			c = 1;
			i = 0;
			if (hole_count == 0 || hole_size[0] < len) return ST_NO_SPACE;
		end
		a = hole_addr[i];
		g = len;
		// grant a too-small leftover along with the job
		if (hole_size[i] - len < min_frag) begin
			g = hole_size[i];
			drop_hole(i);
		end else begin
			hole_addr[i] += len;
			hole_size[i] -= len;
		end
		slot = -1;
		for (int s = 15; s >= 0; s--)
			if (!job_ok[s]) slot = s;
		if (slot < 0) return ST_TABLE_FULL;
		job_ok[slot] = 1;
		job_tag[slot] = tag;
		job_addr[slot] = a;
		job_len[slot] = g;
		jobs++;
		unused -= g;
		return ST_OK;
	endfunction

	function status_t release_job(int unsigned tag, output int unsigned g);
		int          j;
		int unsigned a, l, p;
		bit          below, above;
		g = 0;
		j = find_job(tag);
		if (j < 0) return ST_NOT_FOUND;
		a = job_addr[j];
		l = job_len[j];
		for (p = 0; p < hole_count; p++)
			if (hole_addr[p] > a) break;
		below = p > 0 && hole_addr[p - 1] + hole_size[p - 1] == a;
		above = p < hole_count && hole_addr[p] == a + l;
		// merge with touching neighbours, else insert a new hole
		if (below && above) begin
			hole_size[p - 1] += l + hole_size[p];
			drop_hole(p);
		end else if (below) begin
			hole_size[p - 1] += l;
		end else if (above) begin
			hole_addr[p] = a;
			hole_size[p] += l;
		end else if (hole_count < 17) begin
			for (int unsigned q = hole_count; q > p; q--) begin
				hole_addr[q] = hole_addr[q - 1];
				hole_size[q] = hole_size[q - 1];
			end
			hole_addr[p] = a;
			hole_size[p] = l;
			hole_count++;
		end
		job_ok[j] = 0;
		jobs--;
		unused += l;
		g = l;
		return ST_OK;
	endfunction

	function void note_request(logic kind, logic [7:0] tag, logic [15:0] len);
		grant_t      r;
		int unsigned a, g;
		bit          c;
		a = 0; g = 0; c = 0;
		if (kind == REQ_ALLOC) r.st = allocate(32'(tag), 32'(len), a, g, c);
		else r.st = release_job(32'(tag), g);
		if (r.st != ST_OK || kind != REQ_ALLOC) a = 0;
		if (r.st != ST_OK) g = 0;
		r.addr = a[15:0];
		r.len = g[15:0];
		r.compacted = c;
		r.free = unused[15:0];
		grants_due.push_back(r);
	endfunction

	function void check_result(grant_t got);
		grant_t want;
		if (grants_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: st=%0d addr=%0d len=%0d", got.st, got.addr,
					got.len);
			return;
		end
		want = grants_due.pop_front();
		if (got.st != want.st || got.addr != want.addr || got.len != want.len
				|| got.compacted != want.compacted || got.free != want.free) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp st=%0d addr=%0d len=%0d cmp=%0d free=%0d,",
					want.st, want.addr, want.len, want.compacted, want.free,
					" got st=%0d addr=%0d len=%0d cmp=%0d free=%0d",
					got.st, got.addr, got.len, got.compacted, got.free);
		end
	endfunction
endclass

module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        req_type = REQ_ALLOC;
	logic [7:0]  job_id = 0;
	logic [15:0] request_length = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = CFG_TOTAL;
	logic [15:0] cfg_wdata = 0;
	logic        busy, done, did_compact;
	logic [2:0]  status;
	logic [15:0] granted_address, granted_length, free_total;

	partition_tracker tracker = new();
	int unsigned      quiet_cycles = 0;

	first_fit_partition_allocator_unit dut (.*);

	always #5 clk = ~clk;

	// take every result the cycle it is shown
	always @(posedge clk) begin
		grant_t got;
		if (done) begin
			got.st = status_t'(status);
			got.addr = granted_address;
			got.len = granted_length;
			got.compacted = did_compact;
			got.free = free_total;
			tracker.check_result(got);
		end
	end

	// abort when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send_request(logic kind, logic [7:0] tag, logic [15:0] len);
		int unsigned gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req_type <= kind;
		job_id <= tag;
		request_length <= len;
		do @(posedge clk); while (busy);
		tracker.note_request(kind, tag, len);
	endtask

	// hold off until every result is in, then let the block settle
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (tracker.grants_due.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_region(logic [15:0] tot, logic [15:0] bas, logic [15:0] frag);
		cfg_we <= 1;
		cfg_index <= CFG_TOTAL;
		cfg_wdata <= tot;
		@(posedge clk);
		tracker.configure(CFG_TOTAL, tot);
		cfg_index <= CFG_BASE;
		cfg_wdata <= bas;
		@(posedge clk);
		tracker.configure(CFG_BASE, bas);
		cfg_index <= CFG_MINFRAG;
		cfg_wdata <= frag;
		@(posedge clk);
		tracker.configure(CFG_MINFRAG, frag);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_requests(int unsigned count);
		int unsigned reg_size, pick, len;
		logic [7:0]  tag;
		logic        kind;
		reg_size = tracker.region();
		for (int unsigned n = 0; n < count; n++) begin
			tag = 8'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 23)
				: $urandom_range(0, 255));
			kind = ($urandom_range(0, 99) < 45) ? REQ_RELEASE : REQ_ALLOC;
			pick = $urandom_range(0, 99);
			if (pick < 5) len = $urandom_range(0, 65535);
			else if (pick < 8) len = 0;
			else if (pick < 13) len = $urandom_range(reg_size / 2, reg_size);
			else len = $urandom_range(1, (reg_size / 10 > 1) ? reg_size / 10 : 1);
			send_request(kind, tag, len[15:0]);
		end
	endtask

	initial begin
		static logic [15:0] cfg_set[5][3] = '{
			'{16'd1, 16'd32767, 16'd0},
			'{16'd32768, 16'd32767, 16'd32768},
			'{16'd65535, 16'd0, 16'd65535},
			'{16'd1000, 16'd12345, 16'd0},
			'{16'd300, 16'd100, 16'd10}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: length limits, duplicates, unknown ids, full table, compaction
		send_request(REQ_ALLOC, 8'd0, 16'd0);
		send_request(REQ_ALLOC, 8'd0, 16'hFFFF);
		send_request(REQ_ALLOC, 8'd255, 16'd1);
		send_request(REQ_ALLOC, 8'd255, 16'd5);
		send_request(REQ_RELEASE, 8'd7, 16'hFFFF);
		send_request(REQ_RELEASE, 8'd255, 16'd0);
		for (int i = 0; i < 16; i++) send_request(REQ_ALLOC, i[7:0], 16'd300);
		send_request(REQ_ALLOC, 8'd16, 16'd10);
		for (int i = 0; i < 8; i += 2) send_request(REQ_RELEASE, i[7:0], 16'd0);
		send_request(REQ_ALLOC, 8'd20, 16'd5000);
		send_request(REQ_ALLOC, 8'd20, 16'd1000);
		random_requests(340);
		drain();

		foreach (cfg_set[p]) begin
			write_region(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2]);
			random_requests(330);
			drain();
		end

		if (tracker.mismatches == 0 && tracker.grants_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
